@@ design/u16u8_pkg.sv @@
package u16u8_pkg;

	// Surrogate ranges and the replacement character
	localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
	localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
	localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
	localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
	localparam logic [15:0] REPLACE_CP   = 16'hFFFD;
	localparam logic [20:0] SUPP_BASE    = 21'h010000;

	// U+FFFD in UTF-8, index 0 goes out first
	localparam logic [2:0][7:0] FFFD_BYTES = {8'hBD, 8'hBF, 8'hEF};

	// Bytes of one encoded code point, index 0 first
	typedef struct packed {
		logic [2:0]      nbytes;
		logic [3:0][7:0] bytes;
	} enc_t;

	// One queued request: optional U+FFFD prefix, then up to four bytes
	typedef struct packed {
		logic            fffd;
		logic [2:0]      nbytes;
		logic [3:0][7:0] bytes;
	} job_t;

	// Queue status toward the front end
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	// UTF-8 encoding of a code point below U+10000
	function automatic enc_t encode_bmp(input logic [15:0] cp);
		enc_t e;
		e = '0;
		priority if (cp < 16'h0080) begin
			e.nbytes   = 3'd1;
			e.bytes[0] = cp[7:0];
		end else if (cp < 16'h0800) begin
			e.nbytes   = 3'd2;
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
		end else begin
			e.nbytes   = 3'd3;
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

@@ design/u16u8_front.sv @@
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  q_stat_t     q_stat,
	output logic        push,
	output job_t        push_job
);

	logic       pending_q, pending_d;
	logic [9:0] high_bits_q, high_bits_d;
	logic       started_q, started_d;
	logic       accept;
	logic       is_high, is_low, is_zero;
	logic [20:0] supp_cp;
	enc_t       enc;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	// Classify the incoming unit
	assign is_zero = (code_unit == 16'd0);
	assign is_high = (code_unit >= HIGH_SURR_LO) && (code_unit <= HIGH_SURR_HI);
	assign is_low  = (code_unit >= LOW_SURR_LO) && (code_unit <= LOW_SURR_HI);
	assign supp_cp = SUPP_BASE + {1'b0, high_bits_q, code_unit[9:0]};

	// Build the request and next surrogate state
	always_comb begin
		push        = 1'b0;
		push_job    = '0;
		enc         = '0;
		pending_d   = pending_q;
		high_bits_d = high_bits_q;
		started_d   = started_q;
		if (accept) begin
			if (is_zero) begin
				// terminator: flush held surrogate, emit 0 once a unit came, back to reset state
				push            = started_q;
				push_job.fffd   = pending_q;
				push_job.nbytes = 3'd1;
				pending_d       = 1'b0;
				high_bits_d     = '0;
				started_d       = 1'b0;
			end else begin
				started_d = 1'b1;
				if (pending_q && is_low) begin
					// surrogate pair -> four bytes
					push              = 1'b1;
					push_job.nbytes   = 3'd4;
					push_job.bytes[0] = {5'b11110, supp_cp[20:18]};
					push_job.bytes[1] = {2'b10, supp_cp[17:12]};
					push_job.bytes[2] = {2'b10, supp_cp[11:6]};
					push_job.bytes[3] = {2'b10, supp_cp[5:0]};
					pending_d         = 1'b0;
					high_bits_d       = '0;
				end else begin
					push_job.fffd = pending_q;
					pending_d     = 1'b0;
					high_bits_d   = '0;
					if (is_high) begin
						pending_d   = 1'b1;
						high_bits_d = code_unit[9:0];
					end else if (is_low) begin
						enc = encode_bmp(REPLACE_CP);
					end else begin
						enc = encode_bmp(code_unit);
					end
					push_job.nbytes = enc.nbytes;
					push_job.bytes  = enc.bytes;
					push            = pending_q || !is_high;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			high_bits_q <= '0;
			started_q   <= 1'b0;
		end else begin
			pending_q   <= pending_d;
			high_bits_q <= high_bits_d;
			started_q   <= started_d;
		end
	end

endmodule

@@ design/u16u8_queue.sv @@
module u16u8_queue
	import u16u8_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output q_stat_t q_stat,
	output job_t    head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_stat.valid = (count_q != '0);
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign head         = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

@@ design/u16u8_back.sv @@
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  job_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	job_t       cur_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       out_free;
	logic [2:0] pre_len, total, sel;
	logic [7:0] cur_byte;
	logic       is_last;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Pick the byte at the current position
	assign pre_len = cur_q.fffd ? 3'd3 : 3'd0;
	assign total   = pre_len + cur_q.nbytes;
	assign sel     = idx_q - pre_len;
	assign is_last = (idx_q == total - 3'd1);
	always_comb begin
		if (cur_q.fffd && idx_q < 3'd3)
			cur_byte = FFFD_BYTES[idx_q[1:0]];
		else
			cur_byte = cur_q.bytes[sel[1:0]];
	end

	// Take the next request as the current one finishes
	assign pop = q_valid && (!busy_q || (out_free && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free)
				out_valid_q <= busy_q;
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && out_free) begin
				if (is_last)
					busy_q <= 1'b0;
				else
					idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Request payload and output data
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (out_free && busy_q) begin
			out_byte_q <= cur_byte;
			run_last_q <= is_last;
		end
	end

endmodule

@@ design/utf16_to_utf8_transcoder_core.sv @@
// A unit passes the queue, the current-request and the output registers.
// Throughput: one output byte per cycle while out_stall is low; a unit's
// 1 to 6 bytes hold the byte serializer, a held high surrogate or an empty
// terminator takes none. Input is taken every cycle while the queue has room.
// Reset (arst_n low) clears the surrogate state, the queue and the output.
module utf16_to_utf8_transcoder_core
	import u16u8_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	q_stat_t q_stat;
	logic    push, pop;
	job_t    push_job, head;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_unit (code_unit),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_stat   (q_stat),
		.head     (head)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_stat.valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

	// A zero byte only ever closes the bytes of a unit
	a_zero_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == 8'h00 |-> run_last)
		else $error("zero byte not marked last");

	// A lead byte is always followed by continuation bytes
	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte[7:6] == 2'b11 |-> !run_last)
		else $error("multi-byte lead marked last");

	// Once a non-final byte is taken, the next byte follows without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> out_valid)
		else $error("gap inside a multi-byte sequence");

endmodule
